// File: rtl/core/mk_scan_pkg.sv
`default_nettype none

package mk_scan_pkg;

    localparam int ROW_W     = 4;
    localparam int COL_W     = 3;
    localparam int COL_IDX_W = 2;
    localparam int KEY_BITS  = 12;
    localparam int KEY_IDX_W = 4;
    localparam int ROW_PITCH = 3;
    localparam int CODE_W    = 8;
    localparam int SETTLE_W  = 16;
    localparam int MAP_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE_TICKS = 2'd0,
        CFG_MAP_LOW      = 2'd1,
        CFG_MAP_HIGH     = 2'd2
    } cfg_idx_t;

    // byte of the key map for one key, rows 0-1 in the low word, rows 2-3 in the high word
    function automatic logic [CODE_W-1:0] key_code_at(
        input logic [MAP_W-1:0]     map_low,
        input logic [MAP_W-1:0]     map_high,
        input logic [1:0]           row,
        input logic [COL_IDX_W-1:0] col
    );
        logic [MAP_W-1:0] src;
        logic [2:0]       slot;
        src  = row[1] ? map_high : map_low;
        slot = (row[0] ? 3'd3 : 3'd0) + {1'b0, col};
        return src[8*slot +: CODE_W];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/matrix_keypad_scanner.sv
`default_nettype none
// 4x3 key matrix scanner, one tick per request.
// each accepted request's result is registered in the output register.
// throughput: one request per cycle; in_stall rises only while a result waits under out_stall.
// a full scan takes 1 + COLS * (settle_ticks + 1) requests.
// reset: asynchronous, active low; idle, key maps cleared, settle_ticks back to 10.

module matrix_keypad_scanner #(
    parameter int ROWS = 4,
    parameter int COLS = 3
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cfg_write,
    input  wire logic [mk_scan_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mk_scan_pkg::MAP_W-1:0]        cfg_data,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [mk_scan_pkg::ROW_W-1:0]        row_levels,
    input  wire logic                                 poll_request,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [mk_scan_pkg::COL_W-1:0]             column_drive,
    output logic                                      scan_done,
    output logic [mk_scan_pkg::CODE_W-1:0]            key_code,
    output logic                                      busy_res
);

    localparam logic [mk_scan_pkg::ROW_W-1:0] ROW_MASK =
        mk_scan_pkg::ROW_W'((1 << ROWS) - 1);
    localparam logic [mk_scan_pkg::COL_IDX_W:0] COL_LAST = (mk_scan_pkg::COL_IDX_W + 1)'(COLS);

    logic [mk_scan_pkg::SETTLE_W-1:0]  settle_ticks_reg;
    logic [mk_scan_pkg::MAP_W-1:0]     map_low_reg;
    logic [mk_scan_pkg::MAP_W-1:0]     map_high_reg;

    logic                              scanning_reg, scanning_next;
    logic [mk_scan_pkg::COL_IDX_W-1:0] col_reg, col_next;
    logic [mk_scan_pkg::SETTLE_W-1:0]  count_reg, count_next;
    logic [mk_scan_pkg::KEY_BITS-1:0]  scan_reg, scan_next;
    logic [mk_scan_pkg::KEY_BITS-1:0]  prev_reg, prev_next;

    logic                              out_valid_reg;
    logic [mk_scan_pkg::COL_W-1:0]     column_drive_reg, column_drive_next;
    logic                              scan_done_reg, scan_done_next;
    logic [mk_scan_pkg::CODE_W-1:0]    key_code_reg, key_code_next;
    logic                              busy_reg;

    logic [mk_scan_pkg::ROW_W-1:0]     rows_masked;
    logic [mk_scan_pkg::KEY_BITS-1:0]  sampled;
    logic                              row_hit;
    logic                              finish;
    logic [mk_scan_pkg::KEY_IDX_W-1:0] key_idx;
    logic                              accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign rows_masked = row_levels & ROW_MASK;

    always_comb
    begin
        scanning_next  = scanning_reg;
        col_next       = col_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        prev_next      = prev_reg;
        sampled        = scan_reg;
        row_hit        = 1'b0;
        finish         = 1'b0;
        scan_done_next = 1'b0;
        key_code_next  = '0;
        key_idx        = '0;

        if (!scanning_reg)
        begin
            if (poll_request)
            begin
                scanning_next = 1'b1;
                col_next      = '0;
                count_next    = '0;
                scan_next     = '0;
            end
        end
        else if ({1'b0, col_reg} >= COL_LAST)
        begin
            finish = 1'b1;
        end
        else if (count_reg < settle_ticks_reg)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            // lowest high row wins for this column
            for (int r = 0; r < ROWS; r++)
            begin
                if (rows_masked[2'(r)] && !row_hit)
                begin
                    key_idx          = mk_scan_pkg::KEY_IDX_W'(r * mk_scan_pkg::ROW_PITCH)
                                       + {2'b00, col_reg};
                    sampled[key_idx] = 1'b1;
                    row_hit          = 1'b1;
                end
            end
            count_next = '0;
            col_next   = col_reg + 1'b1;
            scan_next  = sampled;
            if (({1'b0, col_reg} + 1'b1) >= COL_LAST)
            begin
                finish = 1'b1;
            end
        end

        if (finish)
        begin
            // last new press in column-major order
            for (int c = 0; c < COLS; c++)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    if (sampled[mk_scan_pkg::KEY_IDX_W'(r * mk_scan_pkg::ROW_PITCH + c)]
                        && !prev_reg[mk_scan_pkg::KEY_IDX_W'(r * mk_scan_pkg::ROW_PITCH + c)])
                    begin
                        key_code_next = mk_scan_pkg::key_code_at(map_low_reg, map_high_reg,
                                            2'(r), mk_scan_pkg::COL_IDX_W'(c));
                    end
                end
            end
            prev_next      = sampled;
            scan_next      = '0;
            scanning_next  = 1'b0;
            col_next       = '0;
            count_next     = '0;
            scan_done_next = 1'b1;
        end

        column_drive_next = scanning_next ? (3'b001 << col_next) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= mk_scan_pkg::SETTLE_RESET;
            map_low_reg      <= '0;
            map_high_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mk_scan_pkg::CFG_SETTLE_TICKS:
                    settle_ticks_reg <= cfg_data[mk_scan_pkg::SETTLE_W-1:0];
                mk_scan_pkg::CFG_MAP_LOW:
                    map_low_reg <= cfg_data;
                mk_scan_pkg::CFG_MAP_HIGH:
                    map_high_reg <= cfg_data;
                default:
                begin
                    settle_ticks_reg <= settle_ticks_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg <= 1'b0;
            col_reg      <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
            prev_reg     <= '0;
        end
        else if (accept)
        begin
            scanning_reg <= scanning_next;
            col_reg      <= col_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            prev_reg     <= prev_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            column_drive_reg <= column_drive_next;
            scan_done_reg    <= scan_done_next;
            key_code_reg     <= key_code_next;
            busy_reg         <= scanning_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = column_drive_reg;
    assign scan_done    = scan_done_reg;
    assign key_code     = key_code_reg;
    assign busy_res     = busy_reg;

endmodule

`default_nettype wire

// File: rtl/core/mk_scan_chk.sv
`default_nettype none

module mk_scan_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [mk_scan_pkg::COL_W-1:0]     column_drive,
    input wire logic                              scan_done,
    input wire logic [mk_scan_pkg::CODE_W-1:0]    key_code,
    input wire logic                              busy_res
);

    // a completed scan leaves the scanner idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scan_done |-> !busy_res)
        else $error("scan_done while still busy");

    // key codes only appear at scan end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (key_code != '0) |-> scan_done)
        else $error("key_code outside scan end");

    // exactly one column driven while busy, none when idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (busy_res ? $onehot(column_drive) : (column_drive == '0)))
        else $error("column_drive inconsistent with busy_res");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(column_drive)
            && $stable(scan_done) && $stable(key_code) && $stable(busy_res))
        else $error("stalled result changed");

endmodule

bind matrix_keypad_scanner mk_scan_chk u_mk_scan_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .column_drive (column_drive),
    .scan_done    (scan_done),
    .key_code     (key_code),
    .busy_res     (busy_res)
);

`default_nettype wire

// File: tb/keypad_scan_checker.sv
module keypad_scan_checker
    import mk_scan_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAP_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [ROW_W-1:0]     row_levels,
    input  logic                 poll_request,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [COL_W-1:0]     column_drive,
    input  logic                 scan_done,
    input  logic [CODE_W-1:0]    key_code,
    input  logic                 busy_res,
    output int                   fail_count,
    output int                   pending
);

    localparam int NUM_ROWS = ROW_W;
    localparam int NUM_COLS = COL_W;

    typedef struct packed {
        logic [COL_W-1:0]  drive;
        logic              done;
        logic [CODE_W-1:0] code;
        logic              busy;
    } tick_result_t;

    logic [SETTLE_W-1:0]  settle_ticks;
    logic [MAP_W-1:0]     map_low;
    logic [MAP_W-1:0]     map_high;
    logic                 scanning;
    logic [COL_IDX_W-1:0] col_idx;
    logic [SETTLE_W-1:0]  settle_cnt;
    logic [KEY_BITS-1:0]  scan_keys;
    logic [KEY_BITS-1:0]  held_keys;

    tick_result_t expected_ticks[$];
    tick_result_t want;
    tick_result_t got;

    function automatic logic [CODE_W-1:0] code_of(input int row, input int col);
        logic [MAP_W-1:0] word;
        word = (row < 2) ? map_low : map_high;
        return word[CODE_W*((row % 2)*ROW_PITCH + col) +: CODE_W];
    endfunction

    function automatic logic [CODE_W-1:0] end_scan();
        logic [CODE_W-1:0] code;
        code = '0;
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                if (scan_keys[KEY_IDX_W'(r*ROW_PITCH + c)]
                    && !held_keys[KEY_IDX_W'(r*ROW_PITCH + c)])
                    code = code_of(r, c);
            end
        end
        held_keys  = scan_keys;
        scan_keys  = '0;
        scanning   = 1'b0;
        col_idx    = '0;
        settle_cnt = '0;
        return code;
    endfunction

    function automatic tick_result_t scan_tick(input logic [ROW_W-1:0] rows, input logic req);
        tick_result_t res;
        logic [CODE_W-1:0] code;
        logic done;
        int hit;
        code = '0;
        done = 1'b0;
        if (!scanning) begin
            if (req) begin
                scanning   = 1'b1;
                col_idx    = '0;
                settle_cnt = '0;
                scan_keys  = '0;
            end
        end else if (col_idx >= NUM_COLS) begin
            code = end_scan();
            done = 1'b1;
        end else if (settle_cnt < settle_ticks) begin
            settle_cnt = settle_cnt + 1'b1;
        end else begin
            // only the lowest high row counts
            hit = -1;
            for (int r = NUM_ROWS - 1; r >= 0; r--) begin
                if (rows[2'(r)])
                    hit = r;
            end
            if (hit >= 0)
                scan_keys[KEY_IDX_W'(hit*ROW_PITCH + int'(col_idx))] = 1'b1;
            settle_cnt = '0;
            col_idx    = col_idx + 1'b1;
            if (col_idx >= NUM_COLS) begin
                code = end_scan();
                done = 1'b1;
            end
        end
        res.drive = scanning ? (COL_W'(1) << col_idx) : '0;
        res.done  = done;
        res.code  = code;
        res.busy  = scanning;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            settle_ticks = SETTLE_RESET;
            map_low      = '0;
            map_high     = '0;
            scanning     = 1'b0;
            col_idx      = '0;
            settle_cnt   = '0;
            scan_keys    = '0;
            held_keys    = '0;
            expected_ticks.delete();
            fail_count   = 0;
            pending      = 0;
        end else begin
            if (out_valid && !out_stall) begin
                got = '{column_drive, scan_done, key_code, busy_res};
                if (expected_ticks.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: drive=%0d done=%0d code=%0h busy=%0d",
                                 got.drive, got.done, got.code, got.busy);
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"mismatch: expected drive=%0d done=%0d code=%0h ",
                                      "busy=%0d, got drive=%0d done=%0d code=%0h busy=%0d"},
                                     want.drive, want.done, want.code, want.busy,
                                     got.drive, got.done, got.code, got.busy);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_ticks.push_back(scan_tick(row_levels, poll_request));
            if (cfg_write) begin
                case (cfg_index)
                    CFG_SETTLE_TICKS: settle_ticks = cfg_data[SETTLE_W-1:0];
                    CFG_MAP_LOW:      map_low      = cfg_data;
                    CFG_MAP_HIGH:     map_high     = cfg_data;
                    default:          ;
                endcase
            end
            pending = expected_ticks.size();
        end
    end

endmodule

// File: tb/matrix_keypad_scanner_test.sv
module matrix_keypad_scanner_test;

    import mk_scan_pkg::*;

    localparam int NUM_COLS       = COL_W;
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MAP_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [ROW_W-1:0]     row_levels;
    logic                 poll_request;
    logic                 out_valid;
    logic                 out_stall;
    logic [COL_W-1:0]     column_drive;
    logic                 scan_done;
    logic [CODE_W-1:0]    key_code;
    logic                 busy_res;
    int                   fail_count;
    int                   pending;

    int  cur_settle;
    int  scan_left;
    int  busy_items;
    int  target;
    int  pick;
    int  hold_asks   = 0;
    int  holds_done  = 0;
    int  idle_cycles = 0;
    bit  no_idle     = 1'b0;
    logic [NUM_COLS-1:0][ROW_W-1:0] held;

    matrix_keypad_scanner u_top (.*);

    keypad_scan_checker u_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [MAP_W-1:0] rand_map();
        logic [31:0] upper;
        logic [31:0] lower;
        upper = $urandom();
        lower = $urandom();
        return {upper[15:0], lower};
    endfunction

    task automatic send_item(input logic [ROW_W-1:0] rows, input logic req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        row_levels   <= rows;
        poll_request <= req;
        do @(posedge clk); while (in_stall);
        if (scan_left > 0) begin
            scan_left--;
            busy_items++;
        end else if (req) begin
            scan_left = NUM_COLS*(cur_settle + 1);
            busy_items++;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic close_scan();
        while (scan_left > 0)
            send_item(ROW_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_SETTLE_TICKS)
            cur_settle = int'(data[SETTLE_W-1:0]);
    endtask

    task automatic reconfigure(input logic [SETTLE_W-1:0] settle,
                               input logic [MAP_W-1:0] lo, input logic [MAP_W-1:0] hi);
        logic [31:0] junk;
        close_scan();
        drain();
        junk = $urandom();
        write_reg(CFG_SETTLE_TICKS, {junk, settle});
        write_reg(CFG_MAP_LOW, lo);
        write_reg(CFG_MAP_HIGH, hi);
    endtask

    // one well-formed scan, noise on the settle requests
    task automatic run_scan(input logic [NUM_COLS-1:0][ROW_W-1:0] samples);
        close_scan();
        send_item(ROW_W'($urandom_range(0, 15)), 1'b1);
        for (int c = 0; c < NUM_COLS; c++) begin
            repeat (cur_settle)
                send_item(ROW_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            send_item(samples[c], 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic shuffle_held();
        for (int c = 0; c < NUM_COLS; c++) begin
            if ($urandom_range(0, 2) == 0)
                held[c] = ROW_W'($urandom_range(0, 15));
            else if ($urandom_range(0, 7) == 0)
                held[c] = '0;
        end
    endtask

    initial begin
        int wait_cycles;
        out_stall = 1'b0;
        forever begin
            if (holds_done < hold_asks) begin
                wait_cycles = LONG_HOLD;
                holds_done++;
            end else begin
                wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
            end
            repeat (wait_cycles) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_SETTLE_TICKS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        row_levels   = '0;
        poll_request = 1'b0;
        cur_settle   = int'(SETTLE_RESET);
        scan_left    = 0;
        busy_items   = 0;
        held         = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: default settle time, all key codes zero
        send_item(4'hf, 1'b0);
        run_scan({4'h2, 4'h0, 4'h9});
        drain();

        reconfigure(16'd0, 48'ha1b2_c3d4_e500, 48'hff80_7e01_5a3c);
        send_item(4'hf, 1'b0);
        run_scan({4'h0, 4'h8, 4'hf});
        run_scan({4'h0, 4'h8, 4'hf});
        run_scan({4'h8, 4'h0, 4'h0});
        run_scan({4'hc, 4'h4, 4'h2});
        run_scan({4'h0, 4'h0, 4'h1});

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       reconfigure(16'd0, rand_map(), rand_map());
                1:       reconfigure(16'd3, rand_map(), rand_map());
                2:       reconfigure(16'd1, '1, '1);
                3:       reconfigure(16'd2, rand_map(), rand_map());
                4:       reconfigure(SETTLE_W'($urandom_range(4, 9)), '0, '0);
                default: reconfigure(16'd0, rand_map(), rand_map());
            endcase
            if (phase == 2)
                write_reg(CFG_SPARE, rand_map());
            if (phase == 1)
                hold_asks++;
            no_idle = (phase == 3);
            target = busy_items + 120;
            while (busy_items < target) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    repeat ($urandom_range(1, 6))
                        send_item(ROW_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                end else if (pick == 1) begin
                    repeat ($urandom_range(1, 3))
                        send_item(ROW_W'($urandom_range(0, 15)), 1'b0);
                end else begin
                    shuffle_held();
                    run_scan(held);
                end
            end
        end

        // long settle time, one full scan at full rate
        no_idle = 1'b1;
        reconfigure(16'd20, rand_map(), rand_map());
        shuffle_held();
        run_scan(held);
        no_idle = 1'b0;

        close_scan();
        drain();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
